// ===== design/assert_macros.svh =====
// assertion macros shared by the parser modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain invariant, checked at every edge out of reset
`define WAVP_ASSERT(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

// same-cycle implication
`define WAVP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WAVP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/wavp_pkg.sv =====
// types and constants of the wav header and pcm parser
package wavp_pkg;

	localparam logic [1:0] KIND_FORMAT = 2'd0;
	localparam logic [1:0] KIND_SAMPLE = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [2:0] ERR_NOT_RIFF    = 3'd0;
	localparam logic [2:0] ERR_NOT_WAVE    = 3'd1;
	localparam logic [2:0] ERR_NO_FMT      = 3'd2;
	localparam logic [2:0] ERR_BAD_FORMAT  = 3'd3;
	localparam logic [2:0] ERR_NO_DATA     = 3'd4;
	localparam logic [2:0] ERR_NO_CHANNELS = 3'd5;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_JUNK = 32'h4B4E_554A;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_LIST = 32'h5453_494C;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [31:0] FMT_CHUNK_SIZE = 32'd16;
	localparam logic [15:0] FMT_PCM        = 16'd1;
	localparam logic [15:0] BITS_8         = 16'd8;
	localparam logic [15:0] BITS_16        = 16'd16;
	localparam logic [30:0] SAT31          = 31'h7FFF_FFFF;
	localparam logic [7:0]  PCM8_OFFSET    = 8'h80;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       start_of_file;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [2:0]         error_code;
		logic signed [15:0] sample_value;
		logic               channel_index;
		logic [30:0]        sample_rate;
		logic [1:0]         used_channels;
		logic [4:0]         bits_per_sample;
		logic [30:0]        frame_count;
		logic               last_sample;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic       restart;
		logic       hdr;
		logic       len2;
		logic       skip;
		logic       samples;
		logic       ld_fmtsize;
		logic       ld_afmt;
		logic       ld_chan;
		logic       ld_rate;
		logic       ld_bits;
		logic       ld_junk;
		logic       ld_list;
		logic       div_start;
		logic       emit_err;
		logic       emit_fmt;
		logic       emit_smp;
		logic [2:0] err_code;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic field_done;
		logic eq_riff;
		logic eq_wave;
		logic eq_junk;
		logic eq_fmt;
		logic eq_list;
		logic eq_data;
		logic size_empty;
		logic bits_ok;
		logic fmt_bad;
		logic chan_zero;
		logic skip_last;
		logic smp_emit;
		logic frames_end;
		logic div_done;
		logic q_zero;
	} status_t;

endpackage

// ===== design/wavp_div.sv =====
// restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit a cycle
module wavp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [31:0] quot
);

	logic        run_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [15:0] rem_q;
	logic [15:0] dvs_q;
	logic [31:0] quo_q;
	logic [16:0] shifted;
	logic [16:0] diff;
	logic        ge;

	always_comb begin
		shifted = {rem_q, quo_q[31]};
		diff    = shifted - {1'b0, dvs_q};
		ge      = shifted >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == '1) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? diff[15:0] : shifted[15:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// ===== design/wavp_datapath.sv =====
// field assembly, header registers, sample counters and result build
module wavp_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  wavp_pkg::in_item_t in_item,
	input  wavp_pkg::cmd_t     cmd,
	output wavp_pkg::status_t  st,
	output logic               res_valid,
	output wavp_pkg::out_item_t res_item
);

	logic [1:0]  bif_q;
	logic [1:0]  bif_eff;
	logic [1:0]  bif_inc;
	logic [31:0] fs_q;
	logic [31:0] fs_eff;
	logic [31:0] fs_new;
	logic [31:0] skip_q;
	logic [31:0] skip_dec;
	logic [15:0] chan_q;
	logic        is16_q;
	logic [31:0] rate_q;
	logic [30:0] ftot_q;
	logic [30:0] fdone_q;
	logic [31:0] fdone_inc;
	logic [15:0] cif_q;
	logic [15:0] cif_inc;
	logic        frame_wrap;
	logic [7:0]  low_q;
	logic        fmt_bad_q;
	logic        smp_word;
	logic [15:0] smp_value;
	logic        smp_last;
	logic [31:0] div_dividend;
	logic [31:0] div_quot;
	logic        div_done;
	logic [30:0] q_sat;

	wavp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (chan_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	always_comb begin
		// a restart byte sees a fresh field
		bif_eff = cmd.restart ? 2'd0 : bif_q;
		fs_eff  = cmd.restart ? 32'd0 : fs_q;
		fs_new  = fs_eff | ({24'd0, in_item.file_byte} << {bif_eff, 3'b000});
		bif_inc = bif_eff + 2'd1;

		skip_dec   = skip_q - 32'd1;
		cif_inc    = cif_q + 16'd1;
		frame_wrap = cif_inc >= chan_q;
		fdone_inc  = {1'b0, fdone_q} + 32'd1;
		smp_word   = !(is16_q && bif_q == 2'd0);
		smp_value  = is16_q ? {in_item.file_byte, low_q}
		                    : {in_item.file_byte ^ wavp_pkg::PCM8_OFFSET, 8'h00};
		smp_last   = (cif_q == {15'd0, chan_q > 16'd1}) && (fdone_inc == {1'b0, ftot_q});

		div_dividend = is16_q ? {1'b0, fs_new[31:1]} : fs_new;
		q_sat        = div_quot[31] ? wavp_pkg::SAT31 : div_quot[30:0];

		st.field_done = (bif_inc == 2'd0) || (cmd.len2 && bif_inc[1]);
		st.eq_riff    = fs_new == wavp_pkg::TAG_RIFF;
		st.eq_wave    = fs_new == wavp_pkg::TAG_WAVE;
		st.eq_junk    = fs_new == wavp_pkg::TAG_JUNK;
		st.eq_fmt     = fs_new == wavp_pkg::TAG_FMT;
		st.eq_list    = fs_new == wavp_pkg::TAG_LIST;
		st.eq_data    = fs_new == wavp_pkg::TAG_DATA;
		// negative sizes skip nothing
		st.size_empty = (fs_new == 32'd0) || fs_new[31];
		st.bits_ok    = (fs_new[15:0] == wavp_pkg::BITS_8) || (fs_new[15:0] == wavp_pkg::BITS_16);
		st.fmt_bad    = fmt_bad_q;
		st.chan_zero  = chan_q == 16'd0;
		st.skip_last  = skip_dec == 32'd0;
		st.smp_emit   = smp_word && (cif_q[15:1] == 15'd0);
		st.frames_end = smp_word && frame_wrap && (fdone_inc >= {1'b0, ftot_q});
		st.div_done   = div_done;
		st.q_zero     = div_quot == 32'd0;

		res_valid = cmd.emit_err | cmd.emit_fmt | cmd.emit_smp;
		res_item  = '0;
		if (cmd.emit_err) begin
			res_item.kind       = wavp_pkg::KIND_ERROR;
			res_item.error_code = cmd.err_code;
		end else if (cmd.emit_fmt) begin
			res_item.kind            = wavp_pkg::KIND_FORMAT;
			res_item.sample_rate     = rate_q[31] ? wavp_pkg::SAT31 : rate_q[30:0];
			res_item.used_channels   = (chan_q > 16'd1) ? 2'd2 : 2'd1;
			res_item.bits_per_sample = is16_q ? 5'd16 : 5'd8;
			res_item.frame_count     = q_sat;
		end else if (cmd.emit_smp) begin
			res_item.kind          = wavp_pkg::KIND_SAMPLE;
			res_item.sample_value  = $signed(smp_value);
			res_item.channel_index = cif_q[0];
			res_item.last_sample   = smp_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bif_q     <= '0;
			fs_q      <= '0;
			skip_q    <= '0;
			chan_q    <= '0;
			is16_q    <= 1'b0;
			ftot_q    <= '0;
			fdone_q   <= '0;
			cif_q     <= '0;
			fmt_bad_q <= 1'b0;
		end else begin
			if (cmd.hdr) begin
				if (st.field_done) begin
					fs_q  <= '0;
					bif_q <= '0;
				end else begin
					fs_q  <= fs_new;
					bif_q <= bif_inc;
				end
			end
			if (cmd.ld_fmtsize)
				fmt_bad_q <= fs_new != wavp_pkg::FMT_CHUNK_SIZE;
			if (cmd.ld_afmt && fs_new[15:0] != wavp_pkg::FMT_PCM)
				fmt_bad_q <= 1'b1;
			if (cmd.ld_chan)
				chan_q <= fs_new[15:0];
			if (cmd.ld_bits)
				is16_q <= fs_new[15:0] == wavp_pkg::BITS_16;
			// junk is padded to an even size, list is not
			if (cmd.ld_junk)
				skip_q <= fs_new[31] ? 32'd0 : fs_new + {31'd0, fs_new[0]};
			if (cmd.ld_list)
				skip_q <= fs_new[31] ? 32'd0 : fs_new;
			if (cmd.skip)
				skip_q <= skip_dec;
			if (cmd.emit_fmt) begin
				ftot_q  <= q_sat;
				fdone_q <= '0;
				cif_q   <= '0;
			end
			if (cmd.samples) begin
				if (!smp_word) begin
					bif_q <= 2'd1;
				end else begin
					bif_q <= 2'd0;
					if (frame_wrap) begin
						cif_q   <= '0;
						fdone_q <= fdone_inc[30:0];
					end else begin
						cif_q <= cif_inc;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_rate)
			rate_q <= fs_new;
		if (cmd.samples && !smp_word)
			low_q <= in_item.file_byte;
	end

endmodule

// ===== design/wavp_ctrl.sv =====
// parse phase state machine
`include "assert_macros.svh"

module wavp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  logic              sof,
	input  wavp_pkg::status_t st,
	output wavp_pkg::cmd_t    cmd,
	output logic              busy
);

	typedef enum logic [22:0] {
		ST_RIFF     = 23'h000001,
		ST_RIFFSIZE = 23'h000002,
		ST_WAVE     = 23'h000004,
		ST_ID1      = 23'h000008,
		ST_JUNKSIZE = 23'h000010,
		ST_JUNKSKIP = 23'h000020,
		ST_FMTID    = 23'h000040,
		ST_FMTSIZE  = 23'h000080,
		ST_AFMT     = 23'h000100,
		ST_CHAN     = 23'h000200,
		ST_RATE     = 23'h000400,
		ST_BRATE    = 23'h000800,
		ST_ALIGN    = 23'h001000,
		ST_BITS     = 23'h002000,
		ST_ID2      = 23'h004000,
		ST_LISTSIZE = 23'h008000,
		ST_LISTSKIP = 23'h010000,
		ST_DATAID   = 23'h020000,
		ST_DATASIZE = 23'h040000,
		ST_DIV      = 23'h080000,
		ST_SAMPLES  = 23'h100000,
		ST_DONE     = 23'h200000,
		ST_HALT     = 23'h400000
	} state_t;

	state_t     state_q;
	state_t     nxt;
	state_t     ph;
	logic [2:0] result_sel;

	always_comb begin
		cmd         = '0;
		nxt         = state_q;
		cmd.restart = acc & sof;
		ph          = cmd.restart ? ST_RIFF : state_q;
		if (state_q == ST_DIV) begin
			if (st.div_done) begin
				cmd.emit_fmt = 1'b1;
				nxt          = st.q_zero ? ST_DONE : ST_SAMPLES;
			end
		end else if (acc) begin
			nxt = ph;
			case (ph)
				ST_JUNKSKIP: begin
					cmd.skip = 1'b1;
					if (st.skip_last)
						nxt = ST_FMTID;
				end
				ST_LISTSKIP: begin
					cmd.skip = 1'b1;
					if (st.skip_last)
						nxt = ST_DATAID;
				end
				ST_SAMPLES: begin
					cmd.samples  = 1'b1;
					cmd.emit_smp = st.smp_emit;
					if (st.frames_end)
						nxt = ST_DONE;
				end
				ST_DONE, ST_HALT: begin
					nxt = ph;
				end
				default: begin
					cmd.hdr  = 1'b1;
					cmd.len2 = ph inside {ST_AFMT, ST_CHAN, ST_ALIGN, ST_BITS};
					if (st.field_done) begin
						case (ph)
							ST_RIFF: begin
								if (st.eq_riff) begin
									nxt = ST_RIFFSIZE;
								end else begin
									cmd.emit_err = 1'b1;
									cmd.err_code = wavp_pkg::ERR_NOT_RIFF;
									nxt          = ST_HALT;
								end
							end
							ST_RIFFSIZE: nxt = ST_WAVE;
							ST_WAVE: begin
								if (st.eq_wave) begin
									nxt = ST_ID1;
								end else begin
									cmd.emit_err = 1'b1;
									cmd.err_code = wavp_pkg::ERR_NOT_WAVE;
									nxt          = ST_HALT;
								end
							end
							ST_ID1: begin
								if (st.eq_junk) begin
									nxt = ST_JUNKSIZE;
								end else if (st.eq_fmt) begin
									nxt = ST_FMTSIZE;
								end else begin
									cmd.emit_err = 1'b1;
									cmd.err_code = wavp_pkg::ERR_NO_FMT;
									nxt          = ST_HALT;
								end
							end
							ST_JUNKSIZE: begin
								cmd.ld_junk = 1'b1;
								nxt         = st.size_empty ? ST_FMTID : ST_JUNKSKIP;
							end
							ST_FMTID: begin
								if (st.eq_fmt) begin
									nxt = ST_FMTSIZE;
								end else begin
									cmd.emit_err = 1'b1;
									cmd.err_code = wavp_pkg::ERR_NO_FMT;
									nxt          = ST_HALT;
								end
							end
							ST_FMTSIZE: begin
								cmd.ld_fmtsize = 1'b1;
								nxt            = ST_AFMT;
							end
							ST_AFMT: begin
								cmd.ld_afmt = 1'b1;
								nxt         = ST_CHAN;
							end
							ST_CHAN: begin
								cmd.ld_chan = 1'b1;
								nxt         = ST_RATE;
							end
							ST_RATE: begin
								cmd.ld_rate = 1'b1;
								nxt         = ST_BRATE;
							end
							ST_BRATE: nxt = ST_ALIGN;
							ST_ALIGN: nxt = ST_BITS;
							ST_BITS: begin
								cmd.ld_bits = 1'b1;
								if (st.fmt_bad || !st.bits_ok) begin
									cmd.emit_err = 1'b1;
									cmd.err_code = wavp_pkg::ERR_BAD_FORMAT;
									nxt          = ST_HALT;
								end else begin
									nxt = ST_ID2;
								end
							end
							ST_ID2: begin
								if (st.eq_list) begin
									nxt = ST_LISTSIZE;
								end else if (st.eq_data) begin
									nxt = ST_DATASIZE;
								end else begin
									cmd.emit_err = 1'b1;
									cmd.err_code = wavp_pkg::ERR_NO_DATA;
									nxt          = ST_HALT;
								end
							end
							ST_LISTSIZE: begin
								cmd.ld_list = 1'b1;
								nxt         = st.size_empty ? ST_DATAID : ST_LISTSKIP;
							end
							ST_DATAID: begin
								if (st.eq_data) begin
									nxt = ST_DATASIZE;
								end else begin
									cmd.emit_err = 1'b1;
									cmd.err_code = wavp_pkg::ERR_NO_DATA;
									nxt          = ST_HALT;
								end
							end
							ST_DATASIZE: begin
								if (st.chan_zero) begin
									cmd.emit_err = 1'b1;
									cmd.err_code = wavp_pkg::ERR_NO_CHANNELS;
									nxt          = ST_HALT;
								end else begin
									cmd.div_start = 1'b1;
									nxt           = ST_DIV;
								end
							end
							default: nxt = ST_HALT;
						endcase
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RIFF;
		end else begin
			state_q <= nxt;
		end
	end

	assign busy       = state_q == ST_DIV;
	assign result_sel = {cmd.emit_err, cmd.emit_fmt, cmd.emit_smp};

	`WAVP_ASSERT(a_one_result, clk, arst_n, $onehot0(result_sel), "more than one result in a cycle")
	`WAVP_ASSERT_IMPL(a_no_accept_div, clk, arst_n, state_q == ST_DIV, !acc, "byte taken during divide")
	`WAVP_ASSERT_NEXT(a_div_entry, clk, arst_n, cmd.div_start, state_q == ST_DIV, "divide not entered")
	`WAVP_ASSERT_NEXT(a_err_halts, clk, arst_n, cmd.emit_err, state_q == ST_HALT, "error without halt")

endmodule

// ===== design/wavp_outq.sv =====
// two-entry result queue in front of the output port
`include "assert_macros.svh"

module wavp_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  wavp_pkg::out_item_t push_item,
	output logic                full,
	output logic                out_valid,
	input  logic                out_ready,
	output wavp_pkg::out_item_t out_item
);

	logic [1:0]          cnt_q;
	logic                wr_q;
	logic                rd_q;
	logic                pop;
	wavp_pkg::out_item_t ent0_q;
	wavp_pkg::out_item_t ent1_q;

	assign out_valid = cnt_q != 2'd0;
	assign full      = cnt_q == 2'd2;
	assign pop       = out_valid & out_ready;
	assign out_item  = rd_q ? ent1_q : ent0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push && !wr_q)
			ent0_q <= push_item;
		if (push && wr_q)
			ent1_q <= push_item;
	end

	`WAVP_ASSERT_IMPL(a_push_room, clk, arst_n, push, !full, "result pushed into a full queue")

endmodule

// ===== design/wav_header_and_pcm_parser_unit.sv =====
// top level of the wav header and pcm parser
//
//  port group   dir  handshake            payload
//  in_*         in   in_valid/in_ready    in_item  (file_byte, start_of_file)
//  out_*        out  out_valid/out_ready  out_item (format, sample or error result)
//
// one file byte is taken per cycle while the two-entry result queue has room
// the data size byte starts a bit-serial divide by the channel count: input is
// held off until the format result is queued
// samples then flow at one byte per cycle likewise, one result per kept sample
// arst_n clears the parser to expect the riff tag; a start_of_file byte also restarts it
// a full result queue stalls the input side
module wav_header_and_pcm_parser_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  wavp_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output wavp_pkg::out_item_t out_item
);

	logic                acc;
	logic                busy;
	logic                q_full;
	logic                res_valid;
	wavp_pkg::out_item_t res_item;
	wavp_pkg::cmd_t      cmd;
	wavp_pkg::status_t   st;

	assign in_ready = ~busy & ~q_full;
	assign acc      = in_valid & in_ready;

	wavp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.sof    (in_item.start_of_file),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	wavp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.st        (st),
		.res_valid (res_valid),
		.res_item  (res_item)
	);

	wavp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_item (res_item),
		.full      (q_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the wav header and pcm parser
`timescale 1ns / 1ps

module testbench;

	localparam int FEED_TARGET = 1200;
	localparam int QUIET_FROM  = 1000;
	localparam int DRAIN_WAIT  = 80;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum logic [4:0] {
		P_RIFF, P_RIFFSIZE, P_WAVE, P_ID1, P_JUNKSIZE, P_JUNKSKIP, P_FMTID,
		P_FMTSIZE, P_AFMT, P_CHAN, P_RATE, P_BRATE, P_ALIGN, P_BITS,
		P_ID2, P_LISTSIZE, P_LISTSKIP, P_DATAID, P_DATASIZE, P_SAMPLES,
		P_DONE, P_HALT
	} hdr_phase_t;

	typedef struct {
		logic [7:0] fbyte;
		logic       sof;
		bit         typed;
		logic [2:0] code;
	} dir_row_t;

	localparam int DIR_ROWS = 21;
	// no start after reset, bytes after a halt, byte extremes, bad wave tag
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{"R", 1'b0, 1'b0, wavp_pkg::ERR_NOT_RIFF},
		'{"I", 1'b0, 1'b0, wavp_pkg::ERR_NOT_RIFF},
		'{"F", 1'b0, 1'b0, wavp_pkg::ERR_NOT_RIFF},
		'{"G", 1'b0, 1'b1, wavp_pkg::ERR_NOT_RIFF},
		'{"R", 1'b0, 1'b0, wavp_pkg::ERR_NOT_RIFF},
		'{8'h00, 1'b1, 1'b0, wavp_pkg::ERR_NOT_RIFF},
		'{8'hFF, 1'b0, 1'b0, wavp_pkg::ERR_NOT_RIFF},
		'{8'h00, 1'b0, 1'b0, wavp_pkg::ERR_NOT_RIFF},
		'{8'hFF, 1'b0, 1'b1, wavp_pkg::ERR_NOT_RIFF},
		'{"R", 1'b1, 1'b0, wavp_pkg::ERR_NOT_RIFF},
		'{"I", 1'b0, 1'b0, wavp_pkg::ERR_NOT_RIFF},
		'{"F", 1'b0, 1'b0, wavp_pkg::ERR_NOT_RIFF},
		'{"F", 1'b0, 1'b0, wavp_pkg::ERR_NOT_RIFF},
		'{8'hFF, 1'b0, 1'b0, wavp_pkg::ERR_NOT_RIFF},
		'{8'hFF, 1'b0, 1'b0, wavp_pkg::ERR_NOT_RIFF},
		'{8'hFF, 1'b0, 1'b0, wavp_pkg::ERR_NOT_RIFF},
		'{8'hFF, 1'b0, 1'b0, wavp_pkg::ERR_NOT_RIFF},
		'{"W", 1'b0, 1'b0, wavp_pkg::ERR_NOT_WAVE},
		'{"A", 1'b0, 1'b0, wavp_pkg::ERR_NOT_WAVE},
		'{"V", 1'b0, 1'b0, wavp_pkg::ERR_NOT_WAVE},
		'{"e", 1'b0, 1'b1, wavp_pkg::ERR_NOT_WAVE}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	wavp_pkg::in_item_t  in_item = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	wavp_pkg::out_item_t out_item;

	wav_header_and_pcm_parser_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	always #2 clk = ~clk;

	// parser state as the block should hold it
	hdr_phase_t  hdr_phase = P_RIFF;
	int          byte_pos = 0;
	logic [31:0] field_acc = '0;
	logic [31:0] skip_left = '0;
	logic [15:0] file_chans = '0;
	logic [15:0] sample_bits = '0;
	logic [31:0] rate_seen = '0;
	logic [31:0] frames_total = '0;
	logic [31:0] frames_done = '0;
	logic [31:0] chan_pos = '0;
	logic [7:0]  low_held = '0;
	bit          fmt_bad = 1'b0;

	wavp_pkg::out_item_t expected_results [$];
	logic [7:0]  file_bytes [$];
	int          mismatch_count = 0;
	int          fed_bytes = 0;
	int          idle_pct = 20;
	int          stall_pct = 20;
	int          stall_left = 0;
	int          cycle_count = 0;
	bit          quiet = 1'b0;

	function automatic bit halt_with(input logic [2:0] code,
			output wavp_pkg::out_item_t res);
		res = '0;
		res.kind = wavp_pkg::KIND_ERROR;
		res.error_code = code;
		hdr_phase = P_HALT;
		return 1'b1;
	endfunction

	// returns 1 when this byte yields a result, which is left in res
	function automatic bit parse_wav_byte(input logic [7:0] b, input logic sof,
			output wavp_pkg::out_item_t res);
		logic [31:0] v, q;
		logic [15:0] raw;
		int          used, ch, flen;
		bit          last;
		res = '0;
		if (sof) begin
			hdr_phase = P_RIFF;
			byte_pos = 0;
			field_acc = '0;
			skip_left = '0;
			file_chans = '0;
			sample_bits = '0;
			rate_seen = '0;
			frames_total = '0;
			frames_done = '0;
			chan_pos = '0;
			low_held = '0;
			fmt_bad = 1'b0;
		end
		if (hdr_phase == P_DONE || hdr_phase == P_HALT)
			return 1'b0;
		if (hdr_phase == P_JUNKSKIP || hdr_phase == P_LISTSKIP) begin
			skip_left = skip_left - 1;
			if (skip_left == 0)
				hdr_phase = (hdr_phase == P_JUNKSKIP) ? P_FMTID : P_DATAID;
			return 1'b0;
		end
		if (hdr_phase == P_SAMPLES) begin
			if (sample_bits == wavp_pkg::BITS_16 && byte_pos == 0) begin
				low_held = b;
				byte_pos = 1;
				return 1'b0;
			end
			byte_pos = 0;
			raw = (sample_bits == wavp_pkg::BITS_16) ? {b, low_held}
				: {b ^ wavp_pkg::PCM8_OFFSET, 8'h00};
			used = (file_chans > 1) ? 2 : 1;
			ch = chan_pos;
			last = (ch == used - 1) && (frames_done == frames_total - 32'd1);
			chan_pos = chan_pos + 1;
			if (chan_pos >= 32'(file_chans)) begin
				chan_pos = 0;
				frames_done = frames_done + 1;
				if (frames_done >= frames_total)
					hdr_phase = P_DONE;
			end
			if (ch >= used)
				return 1'b0;
			res.kind = wavp_pkg::KIND_SAMPLE;
			res.sample_value = raw;
			res.channel_index = ch[0];
			res.last_sample = last;
			return 1'b1;
		end

		field_acc = field_acc | (32'(b) << (8 * byte_pos));
		byte_pos = (byte_pos + 1) & 3;
		flen = (hdr_phase == P_AFMT || hdr_phase == P_CHAN || hdr_phase == P_ALIGN ||
			hdr_phase == P_BITS) ? 2 : 4;
		if (byte_pos != 0 && byte_pos < flen)
			return 1'b0;
		v = field_acc;
		field_acc = '0;
		byte_pos = 0;

		case (hdr_phase)
			P_RIFF: begin
				if (v != wavp_pkg::TAG_RIFF) return halt_with(wavp_pkg::ERR_NOT_RIFF, res);
				hdr_phase = P_RIFFSIZE;
			end
			P_RIFFSIZE: hdr_phase = P_WAVE;
			P_WAVE: begin
				if (v != wavp_pkg::TAG_WAVE) return halt_with(wavp_pkg::ERR_NOT_WAVE, res);
				hdr_phase = P_ID1;
			end
			P_ID1: begin
				if (v == wavp_pkg::TAG_JUNK) hdr_phase = P_JUNKSIZE;
				else if (v != wavp_pkg::TAG_FMT) return halt_with(wavp_pkg::ERR_NO_FMT, res);
				else hdr_phase = P_FMTSIZE;
			end
			P_JUNKSIZE: begin
				// junk is padded to an even size, a negative size skips nothing
				skip_left = v[31] ? 32'd0 : v + 32'(v[0]);
				hdr_phase = (skip_left != 0) ? P_JUNKSKIP : P_FMTID;
			end
			P_FMTID: begin
				if (v != wavp_pkg::TAG_FMT) return halt_with(wavp_pkg::ERR_NO_FMT, res);
				hdr_phase = P_FMTSIZE;
			end
			P_FMTSIZE: begin
				fmt_bad = (v != wavp_pkg::FMT_CHUNK_SIZE);
				hdr_phase = P_AFMT;
			end
			P_AFMT: begin
				if (v[15:0] != wavp_pkg::FMT_PCM) fmt_bad = 1'b1;
				hdr_phase = P_CHAN;
			end
			P_CHAN: begin
				file_chans = v[15:0];
				hdr_phase = P_RATE;
			end
			P_RATE: begin
				rate_seen = v;
				hdr_phase = P_BRATE;
			end
			P_BRATE: hdr_phase = P_ALIGN;
			P_ALIGN: hdr_phase = P_BITS;
			P_BITS: begin
				sample_bits = v[15:0];
				if (fmt_bad || (sample_bits != wavp_pkg::BITS_8 &&
						sample_bits != wavp_pkg::BITS_16))
					return halt_with(wavp_pkg::ERR_BAD_FORMAT, res);
				hdr_phase = P_ID2;
			end
			P_ID2: begin
				if (v == wavp_pkg::TAG_LIST) hdr_phase = P_LISTSIZE;
				else if (v != wavp_pkg::TAG_DATA) return halt_with(wavp_pkg::ERR_NO_DATA, res);
				else hdr_phase = P_DATASIZE;
			end
			P_LISTSIZE: begin
				skip_left = v[31] ? 32'd0 : v;
				hdr_phase = (skip_left != 0) ? P_LISTSKIP : P_DATAID;
			end
			P_DATAID: begin
				if (v != wavp_pkg::TAG_DATA) return halt_with(wavp_pkg::ERR_NO_DATA, res);
				hdr_phase = P_DATASIZE;
			end
			P_DATASIZE: begin
				if (file_chans == 0) return halt_with(wavp_pkg::ERR_NO_CHANNELS, res);
				q = (v / 32'(sample_bits >> 3)) / 32'(file_chans);
				if (q > 32'(wavp_pkg::SAT31)) q = 32'(wavp_pkg::SAT31);
				frames_total = q;
				frames_done = '0;
				chan_pos = '0;
				hdr_phase = (q != 0) ? P_SAMPLES : P_DONE;
				res.kind = wavp_pkg::KIND_FORMAT;
				res.sample_rate = (rate_seen > 32'(wavp_pkg::SAT31)) ? wavp_pkg::SAT31
					: rate_seen[30:0];
				res.used_channels = (file_chans > 1) ? 2'd2 : 2'd1;
				res.bits_per_sample = sample_bits[4:0];
				res.frame_count = q[30:0];
				return 1'b1;
			end
			default: hdr_phase = P_HALT;
		endcase
		return 1'b0;
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic sof, input bit typed = 1'b0,
			input logic [2:0] code = wavp_pkg::ERR_NOT_RIFF);
		wavp_pkg::out_item_t want;
		@(negedge clk);
		if (!quiet && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{file_byte: b, start_of_file: sof};
		// items go in order, so the expectation can be queued before the transfer
		if (parse_wav_byte(b, sof, want) || typed) begin
			if (typed) begin
				want = '0;
				want.kind = wavp_pkg::KIND_ERROR;
				want.error_code = code;
			end
			expected_results.push_back(want);
		end
		fed_bytes++;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic void put_le(input logic [31:0] v, input int n);
		for (int i = 0; i < n; i++)
			file_bytes.push_back(v[8 * i +: 8]);
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'h7F;
			2: return 8'h80;
			3: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// a mostly well-formed file, with rare bad fields, corruption and truncation
	task automatic build_wav();
		logic [31:0] jsize, lsize, dsize;
		logic [15:0] chans, bits;
		int          bps, frame_bytes, hdr_len, n_smp, roll;
		file_bytes.delete();
		put_le(wavp_pkg::TAG_RIFF, 4);
		put_le($urandom, 4);
		put_le(wavp_pkg::TAG_WAVE, 4);
		if ($urandom_range(2) == 0) begin
			put_le(wavp_pkg::TAG_JUNK, 4);
			jsize = ($urandom_range(7) == 0) ? {1'b1, 31'($urandom)} : $urandom_range(0, 9);
			put_le(jsize, 4);
			if (!jsize[31])
				repeat (jsize + jsize[0]) file_bytes.push_back(pick_byte());
		end
		put_le(wavp_pkg::TAG_FMT, 4);
		put_le(($urandom_range(11) == 0) ? $urandom_range(0, 40) : wavp_pkg::FMT_CHUNK_SIZE,
			4);
		put_le(($urandom_range(11) == 0) ? 16'($urandom) : wavp_pkg::FMT_PCM, 2);
		roll = $urandom_range(19);
		chans = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hFFFF :
			(roll < 5) ? 16'($urandom_range(3, 8)) : 16'($urandom_range(1, 2));
		put_le(chans, 2);
		put_le(($urandom_range(3) == 0) ? $urandom : $urandom_range(8000, 96000), 4);
		put_le($urandom, 4);
		put_le($urandom, 2);
		bits = ($urandom_range(11) == 0) ? 16'($urandom_range(0, 40)) :
			($urandom_range(1) ? wavp_pkg::BITS_16 : wavp_pkg::BITS_8);
		put_le(bits, 2);
		if ($urandom_range(2) == 0) begin
			put_le(wavp_pkg::TAG_LIST, 4);
			lsize = ($urandom_range(7) == 0) ? {1'b1, 31'($urandom)} : $urandom_range(0, 9);
			put_le(lsize, 4);
			if (!lsize[31])
				repeat (lsize) file_bytes.push_back(pick_byte());
		end
		put_le(wavp_pkg::TAG_DATA, 4);
		bps = (bits == wavp_pkg::BITS_16) ? 2 : 1;
		frame_bytes = bps * ((chans == 0) ? 1 : int'(chans));
		roll = $urandom_range(19);
		if (roll == 0)
			dsize = $urandom;
		else if (roll == 1)
			dsize = 32'hFFFF_FFFF;
		else if (chans > 8)
			dsize = $urandom_range(0, 1000);
		else
			dsize = $urandom_range(0, 10) * frame_bytes + $urandom_range(0, frame_bytes - 1);
		put_le(dsize, 4);
		hdr_len = file_bytes.size();
		// huge data sizes are cut short; trailing bytes past the data are ignored
		n_smp = (dsize > 200) ? $urandom_range(0, 24) : int'(dsize) + $urandom_range(0, 3);
		repeat (n_smp) file_bytes.push_back(pick_byte());
		if ($urandom_range(7) == 0)
			file_bytes[$urandom_range(0, hdr_len - 1)] = 8'($urandom);
		if ($urandom_range(9) == 0) begin
			roll = $urandom_range(1, file_bytes.size());
			while (file_bytes.size() > roll) void'(file_bytes.pop_back());
		end
	endtask

	task automatic check_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// receiver side: drops out_ready in random bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(99) < stall_pct) begin
			stall_left <= $urandom_range(0, 6);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		wavp_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transfer, kind %0d", out_item.kind);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("kind", want.kind, out_item.kind);
				check_field("error_code", want.error_code, out_item.error_code);
				check_field("sample_value", want.sample_value, out_item.sample_value);
				check_field("channel_index", want.channel_index, out_item.channel_index);
				check_field("sample_rate", want.sample_rate, out_item.sample_rate);
				check_field("used_channels", want.used_channels, out_item.used_channels);
				check_field("bits_per_sample", want.bits_per_sample,
					out_item.bits_per_sample);
				check_field("frame_count", want.frame_count, out_item.frame_count);
				check_field("last_sample", want.last_sample, out_item.last_sample);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		bit paused;
		int roll, n;
		paused = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int k = 0; k < DIR_ROWS; k++)
			push_byte(dir_rows[k].fbyte, dir_rows[k].sof, dir_rows[k].typed, dir_rows[k].code);

		while (fed_bytes < FEED_TARGET) begin
			roll = $urandom_range(2);
			idle_pct = (roll == 0) ? 0 : (roll == 1) ? 10 : 35;
			roll = $urandom_range(2);
			stall_pct = (roll == 0) ? 0 : (roll == 1) ? 10 : 35;
			quiet = (fed_bytes >= QUIET_FROM);
			if (!paused && fed_bytes >= FEED_TARGET / 2) begin
				// hold off until the block has delivered everything owed
				paused = 1'b1;
				@(negedge clk);
				in_valid <= 1'b0;
				while (expected_results.size() != 0) @(negedge clk);
			end
			if ($urandom_range(99) < 15) begin
				n = $urandom_range(1, 40);
				repeat (n) push_byte(8'($urandom), $urandom_range(7) == 0);
			end else begin
				build_wav();
				foreach (file_bytes[i])
					push_byte(file_bytes[i], i == 0);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== wav_header_and_pcm_parser_unit.f =====
+incdir+design
design/wavp_pkg.sv
design/wavp_div.sv
design/wavp_datapath.sv
design/wavp_ctrl.sv
design/wavp_outq.sv
design/wav_header_and_pcm_parser_unit.sv
tb/sv/testbench.sv
